// ===== design/hffe_pkg.sv =====
// hffe_pkg: shared constants and types of the header/footer frame extractor
// no dependencies; imported by hffe_ctrl and header_footer_frame_extractor

package hffe_pkg;

	localparam int FRAME_BYTES = 64;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 6;
	localparam int IDX_W       = 8;
	localparam int OUT_DATA_W  = 16;

	// fill count at which the next input byte drops the frame
	localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(FRAME_BYTES - 1);

	localparam logic [IDX_W-1:0] REG_HEADER  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FOOT_1  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_FOOT_2  = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_FOOT_3  = IDX_W'(3);

	localparam logic [BYTE_W-1:0] HEADER_RST = 8'hAA;
	localparam logic [BYTE_W-1:0] FOOT_1_RST = 8'h55;
	localparam logic [BYTE_W-1:0] FOOT_2_RST = 8'h0D;
	localparam logic [BYTE_W-1:0] FOOT_3_RST = 8'h0A;

	typedef struct packed {
		logic [BYTE_W-1:0] header_byte;
		logic [BYTE_W-1:0] footer_first;
		logic [BYTE_W-1:0] footer_second;
		logic [BYTE_W-1:0] footer_third;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

// ===== design/hffe_ram.sv =====
// hffe_ram: generic single write, single read synchronous ram
// read data is registered; no package dependency

module hffe_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/hffe_ctrl.sv =====
// hffe_ctrl: byte parser and frame readout sequencer
// depends on hffe_pkg; drives the frame store through a ram_req_t

module hffe_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hffe_pkg::cfg_t           cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [hffe_pkg::BYTE_W-1:0] in_byte,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [hffe_pkg::BYTE_W-1:0] out_byte,
	output logic                     out_last,
	output logic [hffe_pkg::LEN_W-1:0]  out_len,
	output hffe_pkg::ram_req_t       ram_req,
	input  logic [hffe_pkg::BYTE_W-1:0] ram_rdata
);

	import hffe_pkg::*;

	typedef enum logic [1:0] {
		PH_WAIT_HEADER,
		PH_IN_DATA,
		PH_FOOTER_ONE,
		PH_FOOTER_TWO
	} phase_t;

	typedef enum logic [1:0] {
		ST_PARSE,
		ST_READ,
		ST_DATA
	} state_t;

	state_t            st_q;
	phase_t            phase_q;
	logic [ADDR_W-1:0] fill_q;
	logic [ADDR_W-1:0] rd_q;
	logic [ADDR_W-1:0] last_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic [LEN_W-1:0]  out_len_q;

	logic in_fire;
	logic out_free;
	logic full;

	assign in_ready = (st_q == ST_PARSE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign full     = (fill_q == FILL_MAX);

	// writes happen only while parsing and reads only during readout,
	// so the store never sees a read and a write to the same entry at once
	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = fill_q;
		ram_req.wdata = in_byte;
		ram_req.re    = (st_q == ST_READ);
		ram_req.raddr = rd_q;
		if (in_fire) begin
			if (phase_q == PH_WAIT_HEADER) begin
				ram_req.we    = (in_byte == cfg.header_byte);
				ram_req.waddr = '0;
			end else begin
				ram_req.we = !full;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_PARSE;
			phase_q     <= PH_WAIT_HEADER;
			fill_q      <= '0;
			rd_q        <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_len_q   <= '0;
		end else begin
			// in ST_DATA the output register is reloaded whenever it is free
			if (out_valid_q && out_ready && st_q != ST_DATA) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_PARSE: begin
					if (in_fire) begin
						if (phase_q == PH_WAIT_HEADER) begin
							if (in_byte == cfg.header_byte) begin
								fill_q  <= ADDR_W'(1);
								phase_q <= PH_IN_DATA;
							end
						end else if (full) begin
							// store full: drop the frame and the byte
							fill_q  <= '0;
							phase_q <= PH_WAIT_HEADER;
						end else begin
							case (phase_q)
								PH_IN_DATA: begin
									fill_q <= fill_q + ADDR_W'(1);
									if (in_byte == cfg.footer_first) begin
										phase_q <= PH_FOOTER_ONE;
									end
								end
								PH_FOOTER_ONE: begin
									fill_q  <= fill_q + ADDR_W'(1);
									phase_q <= (in_byte == cfg.footer_second) ?
										PH_FOOTER_TWO : PH_IN_DATA;
								end
								PH_FOOTER_TWO: begin
									if (in_byte == cfg.footer_third) begin
										// frame complete, start readout
										phase_q <= PH_WAIT_HEADER;
										fill_q  <= '0;
										last_q  <= fill_q;
										rd_q    <= '0;
										st_q    <= ST_READ;
									end else begin
										fill_q  <= fill_q + ADDR_W'(1);
										phase_q <= PH_IN_DATA;
									end
								end
								default: begin
									fill_q  <= '0;
									phase_q <= PH_WAIT_HEADER;
								end
							endcase
						end
					end
				end
				ST_READ: begin
					st_q <= ST_DATA;
				end
				ST_DATA: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= ram_rdata;
						out_last_q  <= (rd_q == last_q);
						out_len_q   <= LEN_W'(last_q + ADDR_W'(1));
						if (rd_q == last_q) begin
							st_q <= ST_PARSE;
						end else begin
							rd_q <= rd_q + ADDR_W'(1);
							st_q <= ST_READ;
						end
					end
				end
				default: begin
					st_q <= ST_PARSE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_len   = out_len_q;

endmodule

// ===== design/header_footer_frame_extractor.sv =====
// header_footer_frame_extractor: byte stream deframer, top level
// Bytes enter on the s_ channel one transaction each. A byte equal to the
// header register opens a frame; following bytes go into a 64-entry frame
// store until the three footer bytes arrive in a row. The completed frame,
// header and footer included, leaves on the m_ channel one byte per
// transaction, tlast on its final byte and its length in every item.
// Input bytes are accepted back to back while parsing. Once the third footer
// byte is accepted, s_tready drops and the frame is read back out of the
// store byte by byte: a store read (ST_READ), then a load into the output
// register (ST_DATA). The input resumes once the final byte is loaded. A
// stalled receiver holds the readout; the last output byte may still wait
// while new input bytes are taken. A frame that would exceed 63 bytes is
// dropped without output. Reset returns the parser to header search and
// loads the default header and footer values; the store needs no clearing.
// Register writes on the cfg_ channel are always accepted; cfg_ready is tied high.
// depends on hffe_pkg, hffe_ctrl, hffe_ram

module header_footer_frame_extractor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // rx_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hffe_pkg::OUT_DATA_W-1:0]   m_tdata,  // frame_byte, frame_length, zero pad
	output logic                              m_tlast,  // last_byte
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hffe_pkg::IDX_W-1:0]        cfg_index,
	input  logic [hffe_pkg::BYTE_W-1:0]       cfg_data
);

	import hffe_pkg::*;

	cfg_t              cfg_q;
	ram_req_t          ram_req;
	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] out_byte;
	logic [LEN_W-1:0]  out_len;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte   <= HEADER_RST;
			cfg_q.footer_first  <= FOOT_1_RST;
			cfg_q.footer_second <= FOOT_2_RST;
			cfg_q.footer_third  <= FOOT_3_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEADER: cfg_q.header_byte   <= cfg_data;
				REG_FOOT_1: cfg_q.footer_first  <= cfg_data;
				REG_FOOT_2: cfg_q.footer_second <= cfg_data;
				REG_FOOT_3: cfg_q.footer_third  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hffe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (out_byte),
		.out_last  (m_tlast),
		.out_len   (out_len),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	hffe_ram #(
		.DEPTH (FRAME_BYTES),
		.WIDTH (BYTE_W),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	assign m_tdata = {(OUT_DATA_W - LEN_W - BYTE_W)'(0), out_len, out_byte};

	// store is never read and written in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("frame store read and write collide");

	// store writes only come from accepted input bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (s_tvalid && s_tready))
		else $error("frame store written without an input transaction");

	// a read is followed by a cycle with no new read and with s_tready low
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.re |=> !ram_req.re && !s_tready)
		else $error("frame store read data not consumed");

endmodule

// ===== tb/sv/hffe_checker.sv =====
`timescale 1ns / 100ps
// hffe_checker: watches the byte, frame and register channels of the frame extractor,
// rebuilds the expected frame transactions and compares each output transaction to them
// depends on hffe_pkg

module hffe_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // rx_byte
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [hffe_pkg::OUT_DATA_W-1:0] m_tdata,  // frame_byte, frame_length, zero pad
	input  logic                            m_tlast,  // last_byte
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [hffe_pkg::IDX_W-1:0]      cfg_index,
	input  logic [hffe_pkg::BYTE_W-1:0]     cfg_data,
	output int                              fail_count,
	output int                              beats_pending
);

	localparam int BW       = hffe_pkg::BYTE_W;
	localparam int LW       = hffe_pkg::LEN_W;
	localparam int PAD_W    = hffe_pkg::OUT_DATA_W - BW - LW;

	typedef enum logic [1:0] {
		SEEK_HEADER,
		IN_BODY,
		SAW_FOOT1,
		SAW_FOOT2
	} parse_t;

	typedef struct packed {
		logic [LW-1:0] len;
		logic [BW-1:0] data;
		logic          last;
	} frame_beat_t;

	hffe_pkg::cfg_t cfg;
	parse_t         phase;
	int             fill;
	logic [BW-1:0]  store [hffe_pkg::FRAME_BYTES];
	frame_beat_t    beat_q [$];
	int             err_n;

	task automatic flag_mismatch(input string what, input int exp_v, input int act_v);
		err_n++;
		$display("%0t mismatch on %s: expected %0h, actual %0h", $time, what, exp_v, act_v);
	endtask

	task automatic take_rx_byte(input logic [BW-1:0] b);
		frame_beat_t beat;
		if (phase == SEEK_HEADER) begin
			if (b == cfg.header_byte) begin
				store[0] = b;
				fill = 1;
				phase = IN_BODY;
			end
		end else if (fill >= hffe_pkg::FRAME_BYTES - 1) begin
			// store full: frame dropped, this byte lost
			phase = SEEK_HEADER;
			fill = 0;
		end else begin
			store[fill] = b;
			fill++;
			case (phase)
				IN_BODY: begin
					if (b == cfg.footer_first)
						phase = SAW_FOOT1;
				end
				SAW_FOOT1: begin
					phase = (b == cfg.footer_second) ? SAW_FOOT2 : IN_BODY;
				end
				default: begin
					if (b != cfg.footer_third) begin
						phase = IN_BODY;
					end else begin
						for (int k = 0; k < fill; k++) begin
							beat.data = store[k];
							beat.last = (k == fill - 1);
							beat.len  = LW'(fill);
							beat_q.push_back(beat);
						end
						phase = SEEK_HEADER;
						fill = 0;
					end
				end
			endcase
		end
	endtask

	task automatic check_beat();
		frame_beat_t want;
		if (beat_q.size() == 0) begin
			err_n++;
			$display("%0t unexpected output transaction: expected none, actual %0h last %0b",
				$time, m_tdata, m_tlast);
		end else begin
			want = beat_q.pop_front();
			if (m_tdata[BW-1:0] !== want.data)
				flag_mismatch("frame_byte", want.data, m_tdata[BW-1:0]);
			if (m_tdata[BW +: LW] !== want.len)
				flag_mismatch("frame_length", want.len, m_tdata[BW +: LW]);
			if (m_tlast !== want.last)
				flag_mismatch("last_byte", want.last, m_tlast);
			if (m_tdata[hffe_pkg::OUT_DATA_W-1 -: PAD_W] !== '0)
				flag_mismatch("tdata pad", 0, m_tdata[hffe_pkg::OUT_DATA_W-1 -: PAD_W]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.header_byte   = hffe_pkg::HEADER_RST;
			cfg.footer_first  = hffe_pkg::FOOT_1_RST;
			cfg.footer_second = hffe_pkg::FOOT_2_RST;
			cfg.footer_third  = hffe_pkg::FOOT_3_RST;
			phase = SEEK_HEADER;
			fill = 0;
			beat_q.delete();
			err_n = 0;
			fail_count <= 0;
			beats_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hffe_pkg::REG_HEADER: cfg.header_byte   = cfg_data;
					hffe_pkg::REG_FOOT_1: cfg.footer_first  = cfg_data;
					hffe_pkg::REG_FOOT_2: cfg.footer_second = cfg_data;
					hffe_pkg::REG_FOOT_3: cfg.footer_third  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_rx_byte(s_tdata);
			if (m_tvalid && m_tready)
				check_beat();
			fail_count <= err_n;
			beats_pending <= beat_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_header_footer_frame_extractor.sv =====
`timescale 1ns / 100ps
// tb_header_footer_frame_extractor: stimulus and verdict for the frame extractor
// depends on hffe_pkg, header_footer_frame_extractor and hffe_checker

module tb_header_footer_frame_extractor;

	localparam int SETTLE_CYCLES = 160;
	localparam int HOLD_CYCLES   = 400;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [7:0]                      s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [hffe_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tlast;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [hffe_pkg::IDX_W-1:0]      cfg_index;
	logic [hffe_pkg::BYTE_W-1:0]     cfg_data;
	int                              fail_count;
	int                              beats_pending;

	// current register values, for building frames
	logic [7:0] hdr = hffe_pkg::HEADER_RST;
	logic [7:0] f1  = hffe_pkg::FOOT_1_RST;
	logic [7:0] f2  = hffe_pkg::FOOT_2_RST;
	logic [7:0] f3  = hffe_pkg::FOOT_3_RST;

	int n_items   = 0;
	bit src_gaps  = 1'b1;
	bit sink_gaps = 1'b1;
	bit hold_sink = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	header_footer_frame_extractor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hffe_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.beats_pending (beats_pending)
	);

	// body bytes favour f1, f2 and hdr for partial matches; clean ones avoid f1
	function automatic logic [7:0] body_byte(input bit clean);
		logic [7:0] r;
		int pick;
		pick = $urandom_range(0, 9);
		r = 8'($urandom);
		if (clean) begin
			while (r == f1)
				r = 8'($urandom);
		end else if (pick == 0) begin
			r = f1;
		end else if (pick == 1) begin
			r = f2;
		end else if (pick == 2) begin
			r = hdr;
		end
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = src_gaps ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_items++;
	endtask

	task automatic send_frame(input int body_len, input bit clean, input bit broken);
		send_byte(hdr);
		repeat (body_len) send_byte(body_byte(clean));
		if (broken) begin
			// trailer cut off at the second or third byte, frame goes on
			send_byte(f1);
			if ($urandom_range(0, 1)) send_byte(f2);
			send_byte(8'($urandom));
			repeat ($urandom_range(0, 3)) send_byte(body_byte(clean));
		end
		send_byte(f1);
		send_byte(f2);
		send_byte(f3);
	endtask

	task automatic random_traffic(input int budget);
		int stop_at;
		int pick;
		stop_at = n_items + budget;
		while (n_items < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_frame($urandom_range(0, 10), 1'b0, 1'b0);
			end else if (pick < 65) begin
				send_frame($urandom_range(11, 40), 1'b0, 1'b0);
			end else if (pick < 82) begin
				send_frame($urandom_range(0, 6), 1'b0, 1'b1);
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end else begin
				// header left open, next header lands in the body
				send_byte(hdr);
				repeat ($urandom_range(0, 3)) send_byte(body_byte(1'b0));
			end
		end
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] h, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] c);
		write_reg(hffe_pkg::REG_HEADER, h);
		write_reg(hffe_pkg::REG_FOOT_1, a);
		write_reg(hffe_pkg::REG_FOOT_2, b);
		write_reg(hffe_pkg::REG_FOOT_3, c);
		// index past the register map, must change nothing
		write_reg(8'($urandom_range(4, 255)), 8'($urandom));
		cfg_valid <= 1'b0;
		hdr = h;
		f1 = a;
		f2 = b;
		f3 = c;
	endtask

	// wait out every expected transaction, then the readout and parse latency
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (beats_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver: random gaps per transaction, one long hold-off on request
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = sink_gaps ? $urandom_range(0, 10) : 0;
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) begin
				if (hold_sink) begin
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_sink = 1'b0;
					m_tready <= 1'b1;
				end
				@(posedge clk);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [7:0] opening [23];
		logic [7:0] h;
		opening = '{
			8'h12, 8'h00, 8'hFF,                                  // ignored while seeking
			8'hAA, 8'h55, 8'h0D, 8'h0A,                           // shortest frame
			8'hAA, 8'hFF, 8'h55, 8'h0D, 8'h00, 8'h55, 8'h0D, 8'h0A, // third trailer byte wrong
			8'hAA, 8'h55, 8'h55, 8'h0D, 8'h0A, 8'h55, 8'h0D, 8'h0A  // second trailer byte wrong
		};
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) send_byte(opening[i]);
		settle();

		// long receiver stall while frames keep coming
		hold_sink = 1'b1;
		random_traffic(20);
		send_frame(59, 1'b1, 1'b0);
		settle();

		set_config(8'h00, 8'hFF, 8'hFF, 8'hFF);
		random_traffic(20);
		// store overflow, then recovery
		send_byte(hdr);
		repeat (63) send_byte(body_byte(1'b1));
		random_traffic(10);
		settle();

		sink_gaps = 1'b0;
		set_config(8'hFF, 8'h00, 8'h7F, 8'h80);
		random_traffic(20);
		settle();

		src_gaps = 1'b0;
		set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		random_traffic(20);
		settle();

		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		h = 8'($urandom);
		set_config(h, h, 8'($urandom), 8'($urandom));
		random_traffic(20);
		settle();

		set_config(hffe_pkg::HEADER_RST, hffe_pkg::FOOT_1_RST,
			hffe_pkg::FOOT_2_RST, hffe_pkg::FOOT_3_RST);
		src_gaps = 1'b0;
		random_traffic(20);
		settle();

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/hffe_pkg.sv
design/hffe_ram.sv
design/hffe_ctrl.sv
design/header_footer_frame_extractor.sv
tb/sv/hffe_checker.sv
tb/sv/tb_header_footer_frame_extractor.sv
